// ===== sv/btsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btsc_pkg: shared types and constants of the block transpose shift cipher
// Holds the payload structs, the block record metadata, the register map and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package btsc_pkg;

  localparam int unsigned NumSlots = 9;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned PermW    = NumSlots * SlotW;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 4;

  // Register indexes on the configuration port (byte address is 8 * index).
  localparam logic [1:0] RegBlockLen = 2'd0;
  localparam logic [1:0] RegPermMap  = 2'd1;
  localparam logic [1:0] RegShift    = 2'd2;
  localparam logic [1:0] RegMode     = 2'd3;

  localparam logic ModeEncrypt = 1'b0;
  localparam logic ModeDecode  = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
    logic             msg_end;
  } out_item_t;

  // Describes one gathered block as it travels from front to back.
  typedef struct packed {
    logic [CntW-1:0] fill;
    logic            full;
    logic            fin;
  } blk_meta_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkEncrypt,
    BkMap,
    BkEmit
  } bk_state_e;

  function automatic logic [SlotW-1:0] slot_entry(logic [PermW-1:0] pm, logic [CntW-1:0] j);
    return pm[{j, 2'b00} +: SlotW];
  endfunction

endpackage
`default_nettype wire

// ===== sv/block_transpose_shift_cipher_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_transpose_shift_cipher_top: columnar transposition with byte shift
// Gathers message bytes into blocks and emits each block transposed through
// the permutation register and shifted modulo MODULUS (encrypt), or shifted
// back and placed by position (decode).
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Transaction payload
//   in        input      in_valid_i/in_stall_o   in_item_t  (data_byte, last)
//   out       output     out_valid_o/out_stall_i out_item_t (out_byte, out_last, msg_end)
//   config    input      APB psel/penable        64-bit register write or read
//
// The front end takes one byte per cycle as long as the two-entry block queue
// has room; a completed block is queued in the cycle its final byte arrives.
// The back end first loads a block from the queue, then steps slot by slot:
// an encrypt block takes one sweep over the slots, and a decode block holding
// n bytes takes a placement sweep over the slots, then the emission sweep
// over the n positions.
// Reset clears the fill count, the queue, the sequencer and the output valid;
// registers return to block_len=1, perm_map=0, shift=0, mode=0.
// An output stall holds the registered result and freezes the encrypt and
// emission sweeps; input stall rises only while the block queue is full.
//
module block_transpose_shift_cipher_top import btsc_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 9,
  parameter int unsigned MODULUS   = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire in_item_t    in_data_i,
  output      logic        in_stall_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      out_item_t   out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready
);

  localparam int unsigned BytesW = MAX_BLOCK * ByteW;
  localparam int unsigned RecW   = BytesW + $bits(blk_meta_t);

  // Configuration registers.
  logic [CntW-1:0]  block_len_q;
  logic [PermW-1:0] perm_map_q;
  logic [ByteW-1:0] shift_q;
  logic             mode_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic [CntW-1:0]  eff_len;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= 4'd1;
      perm_map_q  <= '0;
      shift_q     <= '0;
      mode_q      <= ModeEncrypt;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBlockLen: block_len_q <= pwdata[CntW-1:0];
        RegPermMap:  perm_map_q  <= pwdata[PermW-1:0];
        RegShift:    shift_q     <= pwdata[ByteW-1:0];
        RegMode:     mode_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegBlockLen: prdata = 64'(block_len_q);
      RegPermMap:  prdata = 64'(perm_map_q);
      RegShift:    prdata = 64'(shift_q);
      RegMode:     prdata = 64'(mode_q);
      default: ;
    endcase
  end

  // A block length of zero behaves as one; anything beyond the buffer is
  // clamped to the buffer depth.
  always_comb begin
    if (block_len_q == '0) begin
      eff_len = 4'd1;
    end else if (block_len_q > CntW'(MAX_BLOCK)) begin
      eff_len = CntW'(MAX_BLOCK);
    end else begin
      eff_len = block_len_q;
    end
  end

  // Front end to queue.
  logic              q_push, q_full, q_pop, q_valid;
  logic [BytesW-1:0] f_bytes, b_bytes;
  blk_meta_t         f_meta, b_meta;
  logic [RecW-1:0]   q_rd_data;

  btsc_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .eff_len_i  (eff_len),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_bytes_o  (f_bytes),
    .q_meta_o   (f_meta)
  );

  btsc_queue #(
    .WIDTH(RecW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({f_meta, f_bytes}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rd_data)
  );

  assign b_bytes = q_rd_data[BytesW-1:0];
  assign b_meta  = q_rd_data[RecW-1:BytesW];

  btsc_back #(
    .MAX_BLOCK(MAX_BLOCK),
    .MODULUS  (MODULUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_bytes_i   (b_bytes),
    .q_meta_i    (b_meta),
    .q_pop_o     (q_pop),
    .eff_len_i   (eff_len),
    .perm_map_i  (perm_map_q),
    .shift_i     (shift_q),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The front end must never hand a block to a full queue.
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("block pushed into a full queue");

  // The back end only takes a record that is present.
  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("block popped from an empty queue");

  // The end of the message always closes a run.
  a_msg_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.msg_end) |-> out_data_o.out_last)
    else $error("message end without end of run");
`endif

endmodule
`default_nettype wire

// ===== sv/btsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btsc_front: byte gathering front end
// Collects message bytes into a block and hands each completed or final
// partial block to the queue as one record.
// ----------------------------------------------------------------------------
module btsc_front import btsc_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 9
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire in_item_t                   in_data_i,
  output      logic                       in_stall_o,
  input  wire logic [CntW-1:0]            eff_len_i,
  input  wire logic                       q_full_i,
  output      logic                       q_push_o,
  output      logic [MAX_BLOCK*ByteW-1:0] q_bytes_o,
  output      blk_meta_t                  q_meta_o
);

  localparam int unsigned IdxW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  logic             accept;
  logic [CntW-1:0]  fill_q, fill_d, fill_inc;
  logic             blk_full, blk_done;
  logic [ByteW-1:0] store_q [MAX_BLOCK];

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign fill_inc   = fill_q + 4'd1;
  assign blk_full   = fill_inc >= eff_len_i;
  assign blk_done   = accept && (blk_full || in_data_i.last);

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = blk_done ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[fill_q[IdxW-1:0]] <= in_data_i.data_byte;
    end
  end

  // The record carries the incoming byte merged into its slot.
  always_comb begin
    for (int i = 0; i < MAX_BLOCK; i++) begin
      q_bytes_o[i*ByteW +: ByteW] = (fill_q == CntW'(i)) ? in_data_i.data_byte : store_q[i];
    end
  end

  assign q_push_o      = blk_done;
  assign q_meta_o.fill = blk_full ? eff_len_i : fill_inc;
  assign q_meta_o.full = blk_full;
  assign q_meta_o.fin  = in_data_i.last;

endmodule
`default_nettype wire

// ===== sv/btsc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btsc_queue: two-entry block record queue
// Decouples the gathering front end from the emitting back end.
// ----------------------------------------------------------------------------
module btsc_queue import btsc_pkg::*; #(
  parameter int unsigned WIDTH = 78
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] mem_q [Depth];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == 2'(Depth);
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/btsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btsc_back: transposition and shift back end
// Walks one block record slot by slot, applies the modular shift and drives
// the registered output stage.
// ----------------------------------------------------------------------------
module btsc_back import btsc_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 9,
  parameter int unsigned MODULUS   = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire logic [MAX_BLOCK*ByteW-1:0] q_bytes_i,
  input  wire blk_meta_t                  q_meta_i,
  output      logic                       q_pop_o,
  input  wire logic [CntW-1:0]            eff_len_i,
  input  wire logic [PermW-1:0]           perm_map_i,
  input  wire logic [ByteW-1:0]           shift_i,
  input  wire logic                       mode_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      out_item_t                  out_data_o
);

  localparam int unsigned IdxW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  // Reduces a byte modulo the modulus by conditional subtraction.
  function automatic logic [ByteW-1:0] mod_byte(logic [ByteW-1:0] x);
    logic [15:0] r;
    int          k;
    r = 16'(x);
    for (k = 7; k >= 0; k--) begin
      if (r >= (16'(MODULUS) << k)) begin
        r = r - (16'(MODULUS) << k);
      end
    end
    return r[ByteW-1:0];
  endfunction

  bk_state_e        state_q, state_d;
  logic [ByteW-1:0] blk_q [MAX_BLOCK];
  logic [ByteW-1:0] pos_q [MAX_BLOCK];
  blk_meta_t        meta_q;
  logic [CntW-1:0]  j_q, j_d, src_q, src_d;
  logic [ByteW-1:0] sadd_q, sadd_d, smod;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic [MAX_BLOCK-1:0] hit, above;
  logic                 cur_hit, more_hits, j_last, emit_last, adv;
  logic [SlotW-1:0]     p;
  logic [CntW-1:0]      from;
  logic [ByteW-1:0]     op_byte, mod_out;
  logic [ByteW:0]       sum;
  logic                 emit, step, pos_wr;
  out_item_t            emit_item;

  assign adv = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < MAX_BLOCK; i++) begin
      hit[i] = (CntW'(i) < eff_len_i) && (slot_entry(perm_map_i, CntW'(i)) < meta_q.fill);
    end
  end

  assign above     = hit >> j_q;
  assign cur_hit   = above[0];
  assign more_hits = |(above >> 1);
  assign j_last    = j_q == (eff_len_i - 4'd1);
  assign emit_last = j_q == (meta_q.fill - 4'd1);
  assign p         = slot_entry(perm_map_i, j_q);
  assign from      = meta_q.full ? j_q : src_q;
  assign op_byte   = (state_q == BkEncrypt) ? blk_q[p[IdxW-1:0]] : blk_q[from[IdxW-1:0]];

  always_comb begin
    sum = 9'(mod_byte(op_byte)) + 9'(sadd_q);
    if (sum >= 9'(MODULUS)) begin
      sum = sum - 9'(MODULUS);
    end
    mod_out = sum[ByteW-1:0];
  end

  // Decode adds the modular complement of the shift.
  always_comb begin
    smod   = mod_byte(shift_i);
    sadd_d = smod;
    if (mode_i == ModeDecode && smod != '0) begin
      sadd_d = ByteW'(9'(MODULUS) - 9'(smod));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          state_d = (mode_i == ModeDecode) ? BkMap : BkEncrypt;
        end
      end
      BkEncrypt: begin
        if (adv && j_last) begin
          state_d = BkIdle;
        end
      end
      BkMap: begin
        if (j_last) begin
          state_d = BkEmit;
        end
      end
      BkEmit: begin
        if (adv && emit_last) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    step      = 1'b0;
    pos_wr    = 1'b0;
    emit_item = '0;
    unique case (state_q)
      BkIdle: begin
        q_pop_o = q_valid_i;
      end
      BkEncrypt: begin
        step      = adv;
        emit      = adv && cur_hit;
        emit_item = '{out_byte: mod_out, out_last: !more_hits,
                      msg_end: meta_q.fin && !more_hits};
      end
      BkMap: begin
        step   = 1'b1;
        pos_wr = cur_hit;
      end
      BkEmit: begin
        step      = adv;
        emit      = adv;
        emit_item = '{out_byte: pos_q[j_q[IdxW-1:0]], out_last: emit_last,
                      msg_end: meta_q.fin && emit_last};
      end
      default: ;
    endcase
  end

  always_comb begin
    j_d   = j_q;
    src_d = src_q;
    if (state_q == BkIdle || (state_q == BkMap && j_last)) begin
      j_d = '0;
    end else if (step) begin
      j_d = j_q + 4'd1;
    end
    if (state_q == BkIdle) begin
      src_d = '0;
    end else if (pos_wr) begin
      src_d = src_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      j_q         <= '0;
      src_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      src_q   <= src_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_item;
    end
    if (q_pop_o) begin
      meta_q <= q_meta_i;
      sadd_q <= sadd_d;
      for (int i = 0; i < MAX_BLOCK; i++) begin
        blk_q[i] <= q_bytes_i[i*ByteW +: ByteW];
        pos_q[i] <= q_bytes_i[i*ByteW +: ByteW];
      end
    end else if (pos_wr) begin
      pos_q[p[IdxW-1:0]] <= mod_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
